/* design/sapk_pkg.sv */
// ---------------------------------------------------------------------------
// sapk_pkg
// Shared types, constants and the side-rounding function of the shelf
// atlas packer.
// ---------------------------------------------------------------------------
package sapk_pkg;

  // Page geometry and page counter limit
  localparam int PAGE_SIZE = 256;
  localparam int MAX_PAGES = 256;

  // Coordinate registers hold values up to PAGE_SIZE inclusive
  localparam int COORD_W = $clog2(PAGE_SIZE) + 1;
  // Sums of two coordinates
  localparam int SUM_W   = COORD_W + 1;
  // Page counter holds values up to MAX_PAGES inclusive
  localparam int PCNT_W  = $clog2(MAX_PAGES) + 1;

  // Fixed field widths
  localparam int RAW_W   = 16;
  localparam int DIM_W   = 10;
  localparam int POS_W   = 8;
  localparam int PIDX_W  = 8;
  localparam int GUT_W   = 4;
  localparam int MAXD_W  = 8;

  // Configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Register indexes
  typedef enum logic {
    REG_GUTTER   = 1'b0,
    REG_MAX_DIM  = 1'b1
  } reg_idx_t;

  localparam logic [GUT_W-1:0]  GUTTER_RST  = GUT_W'(2);
  localparam logic [MAXD_W-1:0] MAX_DIM_RST = MAXD_W'(128);

  typedef struct packed {
    logic [GUT_W-1:0]  gutter;
    logic [MAXD_W-1:0] max_member_dim;
  } cfg_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_width;
    logic [RAW_W-1:0] raw_height;
    logic             new_group;
  } item_t;

  typedef struct packed {
    logic              fits;
    logic [PIDX_W-1:0] page_index;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [DIM_W-1:0]  baked_width;
    logic [DIM_W-1:0]  baked_height;
    logic              opened_page;
  } result_t;

  // Round a raw side to the nearest of 8..512 in powers of two; a tie
  // goes to the smaller value, so each midpoint belongs to the lower step.
  function automatic logic [DIM_W-1:0] bake_side(input logic [RAW_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v <= RAW_W'(12))       r = DIM_W'(8);
    else if (v <= RAW_W'(24))  r = DIM_W'(16);
    else if (v <= RAW_W'(48))  r = DIM_W'(32);
    else if (v <= RAW_W'(96))  r = DIM_W'(64);
    else if (v <= RAW_W'(192)) r = DIM_W'(128);
    else if (v <= RAW_W'(384)) r = DIM_W'(256);
    else                       r = DIM_W'(512);
    return r;
  endfunction

endpackage

/* design/sapk_regs.sv */
// ---------------------------------------------------------------------------
// sapk_regs
// Configuration register file on an APB-style port: gutter and largest
// member side.
// ---------------------------------------------------------------------------
module sapk_regs import sapk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  // Write the addressed register, masked to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gutter         <= GUTTER_RST;
      cfg.max_member_dim <= MAX_DIM_RST;
    end else if (wr_en) begin
      case (idx)
        REG_GUTTER:  cfg.gutter         <= pwdata[GUT_W-1:0];
        REG_MAX_DIM: cfg.max_member_dim <= pwdata[MAXD_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (idx)
      REG_GUTTER:  prdata = APB_DW'(cfg.gutter);
      REG_MAX_DIM: prdata = APB_DW'(cfg.max_member_dim);
      default:     prdata = '0;
    endcase
  end

endmodule

/* design/sapk_place.sv */
// ---------------------------------------------------------------------------
// sapk_place
// Shelf placement unit: holds the packing state and computes one placement
// per cycle from the staged request; the packing state advances only on commit.
// ---------------------------------------------------------------------------
module sapk_place import sapk_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    commit,
  output result_t res
);

  localparam logic [SUM_W-1:0]  PAGE_LIM = SUM_W'(PAGE_SIZE);
  localparam logic [PCNT_W-1:0] PCNT_MAX = PCNT_W'(MAX_PAGES);

  logic [COORD_W-1:0] cursor_x, shelf_top, shelf_height;
  logic [PCNT_W-1:0]  page_count;
  logic               page_open;

  logic [COORD_W-1:0] cursor_x_next, shelf_top_next, shelf_height_next;
  logic [PCNT_W-1:0]  page_count_next;

  logic [DIM_W-1:0]   bw, bh;
  logic [SUM_W-1:0]   cw, ch, g2;
  logic               reject, grp_open, row_wrap, v_over, opened;
  logic [COORD_W-1:0] cx0, st0, sh0, cx1, st1, sh1, cx2, st2, sh2;
  logic [SUM_W-1:0]   st_wrap;
  logic [PCNT_W-1:0]  pc_open;
  logic [PCNT_W-1:0]  pidx_full;

  always_comb begin
    // Bake sides and size the cell with its gutter
    bw     = bake_side(item.raw_width);
    bh     = bake_side(item.raw_height);
    g2     = SUM_W'({cfg.gutter, 1'b0});
    cw     = SUM_W'(bw) + g2;
    ch     = SUM_W'(bh) + g2;
    reject = (bw > DIM_W'(cfg.max_member_dim)) || (bh > DIM_W'(cfg.max_member_dim)) ||
             (cw > PAGE_LIM) || (ch > PAGE_LIM);

    // Fresh page on a group change or before the first page
    grp_open = ~page_open | item.new_group;
    cx0 = grp_open ? '0 : cursor_x;
    st0 = grp_open ? '0 : shelf_top;
    sh0 = grp_open ? '0 : shelf_height;

    // Open a new shelf when the row is full
    row_wrap = (SUM_W'(cx0) + cw) > PAGE_LIM;
    st_wrap  = SUM_W'(st0) + SUM_W'(sh0);
    cx1 = row_wrap ? '0 : cx0;
    st1 = row_wrap ? st_wrap[COORD_W-1:0] : st0;
    sh1 = row_wrap ? '0 : sh0;

    // Fresh page on vertical overflow
    v_over = (SUM_W'(st1) + ch) > PAGE_LIM;
    cx2 = v_over ? '0 : cx1;
    st2 = v_over ? '0 : st1;
    sh2 = v_over ? '0 : sh1;
    opened = grp_open | v_over;

    // Advance the page counter, saturating at the limit
    if (!page_open)                pc_open = PCNT_W'(1);
    else if (page_count < PCNT_MAX) pc_open = page_count + PCNT_W'(1);
    else                           pc_open = page_count;

    page_count_next   = opened ? pc_open : page_count;
    cursor_x_next     = cx2 + cw[COORD_W-1:0];
    shelf_top_next    = st2;
    shelf_height_next = (ch > SUM_W'(sh2)) ? ch[COORD_W-1:0] : sh2;
    pidx_full         = page_count_next - PCNT_W'(1);

    // Build the result; a rejected request reports all zeros
    res = '0;
    if (!reject) begin
      res.fits         = 1'b1;
      res.page_index   = pidx_full[PIDX_W-1:0];
      res.pos_x        = POS_W'(cx2 + COORD_W'(cfg.gutter));
      res.pos_y        = POS_W'(st2 + COORD_W'(cfg.gutter));
      res.baked_width  = bw;
      res.baked_height = bh;
      res.opened_page  = opened;
    end
  end

  // Update packing state on each placed request; rejects leave it alone
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x     <= '0;
      shelf_top    <= '0;
      shelf_height <= '0;
      page_count   <= '0;
      page_open    <= 1'b0;
    end else if (commit && !reject) begin
      cursor_x     <= cursor_x_next;
      shelf_top    <= shelf_top_next;
      shelf_height <= shelf_height_next;
      page_count   <= page_count_next;
      page_open    <= 1'b1;
    end
  end

  // The current shelf never reaches past the bottom of the page
  a_shelf_in_page: assert property (@(posedge clk) disable iff (rst)
    (SUM_W'(shelf_top) + SUM_W'(shelf_height)) <= PAGE_LIM)
    else $error("shelf extends past page bottom");

  // The row cursor stays within the page width
  a_cursor_in_page: assert property (@(posedge clk) disable iff (rst)
    SUM_W'(cursor_x) <= PAGE_LIM)
    else $error("cursor beyond page width");

  // Page count is zero exactly while no page is open, and saturates
  a_page_count: assert property (@(posedge clk) disable iff (rst)
    (page_open == (page_count != '0)) && (page_count <= PCNT_MAX))
    else $error("page counter inconsistent");

  // A placement into an untouched page starts at the gutter corner
  a_fresh_corner: assert property (@(posedge clk) disable iff (rst)
    (commit && res.fits && res.opened_page) |->
      (res.pos_x == POS_W'(cfg.gutter)) && (res.pos_y == POS_W'(cfg.gutter)))
    else $error("fresh page placement not at corner");

endmodule

/* design/shelf_atlas_packer_core.sv */
// ---------------------------------------------------------------------------
// shelf_atlas_packer_core
// Next-fit shelf texture atlas placer: rounds each texture's sides to a
// power of two and places it on a square page with a gutter.
//
//   channel  direction  handshake           payload
//   in       request    in_valid/in_stall   raw_width, raw_height, new_group
//   out      result     out_valid/out_stall fits, page_index, pos_x, pos_y,
//                                           baked_width, baked_height,
//                                           opened_page
//   cfg      APB write  psel/penable/pready gutter (0x0), max_member_dim (0x4)
//
// One request per cycle while out_stall is low; each accepted request is held in
// the input register and its result is presented from the result register.
// The placement is a single pass between the input register and the result
// register, against the packing state held in the placement unit.
// A stalled result holds the result register; the input register still takes
// a request while it is empty, then stalls until the result register drains.
// Synchronous reset clears the packing state and restores the register
// defaults (gutter 2, max_member_dim 128).
// ---------------------------------------------------------------------------
module shelf_atlas_packer_core import sapk_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [RAW_W-1:0]    raw_width,
  input  logic [RAW_W-1:0]    raw_height,
  input  logic                new_group,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic                fits,
  output logic [PIDX_W-1:0]   page_index,
  output logic [POS_W-1:0]    pos_x,
  output logic [POS_W-1:0]    pos_y,
  output logic [DIM_W-1:0]    baked_width,
  output logic [DIM_W-1:0]    baked_height,
  output logic                opened_page,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  cfg_t    cfg;
  item_t   stage;
  logic    stage_valid;
  logic    advance;
  result_t res;
  result_t out_reg;

  sapk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Move the staged request on when the result register is free or draining
  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = stage_valid & ~advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage.raw_width  <= raw_width;
      stage.raw_height <= raw_height;
      stage.new_group  <= new_group;
    end
  end

  sapk_place u_place (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (stage),
    .commit (stage_valid & advance),
    .res    (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      out_reg <= res;
    end
  end

  assign fits         = out_reg.fits;
  assign page_index   = out_reg.page_index;
  assign pos_x        = out_reg.pos_x;
  assign pos_y        = out_reg.pos_y;
  assign baked_width  = out_reg.baked_width;
  assign baked_height = out_reg.baked_height;
  assign opened_page  = out_reg.opened_page;

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shelf atlas packer. A local model of the shelf
// placer predicts each result as its request is accepted, and a receiver
// process compares every result in order. Directed corner cases, sweeps over
// the gutter and size-limit registers, and back-pressure phases are covered.
// ----------------------------------------------------------------------------
module tb_top import sapk_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [RAW_W-1:0]    raw_width = '0;
  logic [RAW_W-1:0]    raw_height = '0;
  logic                new_group = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                fits;
  logic [PIDX_W-1:0]   page_index;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [DIM_W-1:0]    baked_width;
  logic [DIM_W-1:0]    baked_height;
  logic                opened_page;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // Placements still awaited from the block, oldest first
  result_t placements_due[$];
  int      err_count = 0;

  // Idling controls for both sides
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  // Shadow of the packing state and registers
  int cur_x, shelf_y, shelf_h, pages;
  bit have_page;
  int gut, max_dim;

  shelf_atlas_packer_core u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_width    (raw_width),
    .raw_height   (raw_height),
    .new_group    (new_group),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fits         (fits),
    .page_index   (page_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .baked_width  (baked_width),
    .baked_height (baked_height),
    .opened_page  (opened_page),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Round a side to the closest power of two in 8..512; ties keep the smaller
  function automatic int round_side(input logic [RAW_W-1:0] v);
    int best, best_d, d, gap;
    best = 8;
    best_d = 32'h7fff_ffff;
    for (int s = 3; s <= 9; s++) begin
      d = 1 << s;
      gap = (int'(v) > d) ? int'(v) - d : d - int'(v);
      if (gap < best_d) begin
        best_d = gap;
        best = d;
      end
    end
    return best;
  endfunction

  // Start a fresh page; the counter saturates and the last page is reused
  function automatic void start_page();
    if (!have_page) begin
      pages = 1;
      have_page = 1'b1;
    end else if (pages < MAX_PAGES) begin
      pages++;
    end
    cur_x = 0;
    shelf_y = 0;
    shelf_h = 0;
  endfunction

  // Place one texture on the shadow atlas and return the expected result
  function automatic result_t place_texture(input logic [RAW_W-1:0] w,
                                            input logic [RAW_W-1:0] h,
                                            input logic g);
    result_t r;
    int bw, bh, cw, ch;
    bit opened;
    r = '0;
    bw = round_side(w);
    bh = round_side(h);
    cw = bw + 2 * gut;
    ch = bh + 2 * gut;
    opened = 1'b0;
    if (bw > max_dim || bh > max_dim || cw > PAGE_SIZE || ch > PAGE_SIZE)
      return r;
    if (!have_page || g) begin
      start_page();
      opened = 1'b1;
    end
    // Row full: open the next shelf below
    if (cur_x + cw > PAGE_SIZE) begin
      shelf_y += shelf_h;
      cur_x = 0;
      shelf_h = 0;
    end
    // Page full vertically: move on to a new page
    if (shelf_y + ch > PAGE_SIZE) begin
      start_page();
      opened = 1'b1;
    end
    if (ch > shelf_h) shelf_h = ch;
    r.fits         = 1'b1;
    r.page_index   = PIDX_W'(pages - 1);
    r.pos_x        = POS_W'(cur_x + gut);
    r.pos_y        = POS_W'(shelf_y + gut);
    r.baked_width  = DIM_W'(bw);
    r.baked_height = DIM_W'(bh);
    r.opened_page  = opened;
    cur_x += cw;
    return r;
  endfunction

  // Offer one request, idling first at random, and record its placement
  task automatic send_texture(input logic [RAW_W-1:0] w, input logic [RAW_W-1:0] h,
                              input logic g);
    result_t exp_r;
    while (idle_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_width  <= w;
    raw_height <= h;
    new_group  <= g;
    do @(posedge clk); while (in_stall);
    exp_r = place_texture(w, h, g);
    placements_due = {placements_due, exp_r};
  endtask

  function automatic logic [RAW_W-1:0] pick_side();
    int r;
    r = $urandom_range(99);
    if (r < 45) return RAW_W'($urandom_range(24));
    if (r < 80) return RAW_W'($urandom_range(200));
    if (r < 92) return RAW_W'($urandom_range(400));
    return RAW_W'($urandom());
  endfunction

  task automatic send_random(input int n, input int group_pct);
    for (int i = 0; i < n; i++)
      send_texture(pick_side(), pick_side(), $urandom_range(99) < group_pct);
  endtask

  // Hold the request line low until every placement has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase; junk in the unused bits
  task automatic write_reg(input reg_idx_t idx, input int v);
    int w;
    w = (idx == REG_GUTTER) ? GUT_W : MAXD_W;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) * 4);
    pwdata  <= (APB_DW'($urandom()) << w) | APB_DW'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_GUTTER) gut = v & 32'hf;
    else max_dim = v & 32'hff;
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_count++;
    end
  endtask

  // Receiver: check each accepted result, then choose the next stall
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (placements_due.size() == 0) begin
        $error("result arrived with no request outstanding");
        err_count++;
      end else begin
        e = placements_due.pop_front();
        check_field("fits", int'(e.fits), int'(fits));
        check_field("page_index", int'(e.page_index), int'(page_index));
        check_field("pos_x", int'(e.pos_x), int'(pos_x));
        check_field("pos_y", int'(e.pos_y), int'(pos_y));
        check_field("baked_width", int'(e.baked_width), int'(baked_width));
        check_field("baked_height", int'(e.baked_height), int'(baked_height));
        check_field("opened_page", int'(e.opened_page), int'(opened_page));
      end
    end
    if (hold_req) begin
      hold_left = 150;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= stall_on && ($urandom_range(99) < 22);
    end
  end

  // Rounding midpoints, rejections and shelf/page changes at reset settings
  task automatic test_reset_defaults();
    send_texture(16'd0, 16'd0, 1'b0);
    send_texture(16'd12, 16'd13, 1'b0);
    send_texture(16'd24, 16'd25, 1'b0);
    send_texture(16'd48, 16'd49, 1'b0);
    send_texture(16'd96, 16'd97, 1'b0);
    send_texture(16'd192, 16'd192, 1'b0);
    send_texture(16'd193, 16'd8, 1'b0);
    send_texture(16'd8, 16'd384, 1'b0);
    send_texture(16'd385, 16'hffff, 1'b0);
    send_texture(16'hffff, 16'd0, 1'b1);
    send_texture(16'd130, 16'd130, 1'b1);
    send_texture(16'd128, 16'd128, 1'b0);
    send_texture(16'd64, 16'd64, 1'b0);
    send_texture(16'd150, 16'd20, 1'b0);
    send_texture(16'd100, 16'd170, 1'b0);
    send_texture(16'd1, 16'd1, 1'b1);
    send_texture(16'd16, 16'd16, 1'b0);
    send_texture(16'h8000, 16'h4000, 1'b0);
    settle();
  endtask

  // Sweep gutter and size limit, extremes included
  task automatic test_config_sweep();
    int gut_set[6] = '{0, 15, 15, 7, 1, 2};
    int dim_set[6] = '{128, 8, 128, 64, 100, 128};
    for (int k = 0; k < 6; k++) begin
      write_reg(REG_GUTTER, gut_set[k]);
      write_reg(REG_MAX_DIM, dim_set[k]);
      send_random(220, 8);
      settle();
    end
  endtask

  // A long run with neither side idling
  task automatic test_no_idle_stretch();
    idle_on = 1'b0;
    stall_on = 1'b0;
    send_random(250, 8);
    settle();
    idle_on = 1'b1;
    stall_on = 1'b1;
  endtask

  // Receiver holds off while requests keep coming, then the sender pauses
  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_req = 1'b1;
    send_random(50, 8);
    settle();
    idle_on = 1'b1;
    send_random(30, 8);
    settle();
  endtask

  // Push the page counter to its limit and keep placing on the last page
  task automatic test_page_saturation();
    write_reg(REG_GUTTER, 2);
    write_reg(REG_MAX_DIM, 128);
    for (int i = 0; i < 270; i++)
      send_texture(RAW_W'($urandom_range(200)), RAW_W'($urandom_range(200)), 1'b1);
    send_random(60, 5);
    settle();
  endtask

  initial begin
    have_page = 1'b0;
    cur_x = 0;
    shelf_y = 0;
    shelf_h = 0;
    pages = 0;
    gut = int'(GUTTER_RST);
    max_dim = int'(MAX_DIM_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_config_sweep();
    test_no_idle_stretch();
    test_backpressure();
    test_page_saturation();
    repeat (8) @(posedge clk);
    if (err_count == 0 && placements_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
